[hdl/hjs_pkg.sv]
// Shared types, widths and codes of the highest-response-ratio-next job scheduler.
`timescale 1ns / 1ps

package hjs_pkg;

    // Default number of job slots.
    localparam int DEF_MAX_JOBS = 16;

    // Field widths of the request and response channels.
    localparam int SLOT_W   = 4;
    localparam int TIME_W   = 16;
    localparam int STATUS_W = 2;

    // Ratio numerator (wait plus run) and cross product widths.
    localparam int NUM_W  = TIME_W + 1;
    localparam int PROD_W = NUM_W + TIME_W;

    // Request action codes.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_IDLE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RUNNING  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FINISHED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ALL_DONE = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic do_load;
        logic scan_start;
        logic scan_next;
        logic best_take;
        logic early_take;
        logic prod_load;
        logic commit_best;
        logic commit_early;
        logic do_exec;
        logic do_empty;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
        logic out_free;
        logic idx_end;
        logic idx_pending;
        logic cand_arrived;
        logic any_arr;
        logic any_pend;
        logic ratio_greater;
        logic early_better;
    } t_dp_sts;

endpackage

[hdl/hjs_req_if.sv]
// Request channel interface of the job scheduler.
`timescale 1ns / 1ps

interface hjs_req_if;
    import hjs_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] submit_time;
    logic [TIME_W-1:0] run_time;

    modport source (output valid, action, slot, submit_time, run_time, input ready);
    modport sink   (input valid, action, slot, submit_time, run_time, output ready);
endinterface

[hdl/hjs_rsp_if.sv]
// Response channel interface of the job scheduler.
`timescale 1ns / 1ps

interface hjs_rsp_if;
    import hjs_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   finished_slot;
    logic [TIME_W-1:0]   start_time;
    logic [TIME_W-1:0]   end_time;
    logic [TIME_W-1:0]   turnaround;
    logic [TIME_W-1:0]   current_time;

    modport source (output valid, status, finished_slot, start_time, end_time, turnaround,
                    current_time, input ready);
    modport sink   (input valid, status, finished_slot, start_time, end_time, turnaround,
                    current_time, output ready);
endinterface

[hdl/hjs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hjs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

[hdl/hjs_datapath.sv]
// Datapath of the job scheduler: job tables, time keeping, ratio comparator and response register.
`timescale 1ns / 1ps

module hjs_datapath #(
    parameter int MAX_JOBS = hjs_pkg::DEF_MAX_JOBS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [hjs_pkg::SLOT_W-1:0]    i_slot,
    input  logic [hjs_pkg::TIME_W-1:0]    i_submit_time,
    input  logic [hjs_pkg::TIME_W-1:0]    i_run_time,
    input  hjs_pkg::t_dp_cmd              i_cmd,
    output hjs_pkg::t_dp_sts              o_sts,
    input  logic                          i_rsp_ready,
    output logic                          o_rsp_valid,
    output logic [hjs_pkg::STATUS_W-1:0]  o_status,
    output logic [hjs_pkg::SLOT_W-1:0]    o_finished_slot,
    output logic [hjs_pkg::TIME_W-1:0]    o_start_time,
    output logic [hjs_pkg::TIME_W-1:0]    o_end_time,
    output logic [hjs_pkg::TIME_W-1:0]    o_turnaround,
    output logic [hjs_pkg::TIME_W-1:0]    o_current_time
);
    import hjs_pkg::*;

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int ENT_W = 2 * TIME_W;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Slot bookkeeping and scheduler state.
    logic [MAX_JOBS-1:0] r_slot_valid;
    logic [MAX_JOBS-1:0] r_slot_done;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_remaining;
    logic [TIME_W-1:0]   r_job_start;
    logic [IDX_W-1:0]    r_active;
    logic                r_busy;
    logic [TIME_W-1:0]   r_act_sub;
    logic [TIME_W-1:0]   r_act_run;

    // Captured request.
    logic [IDX_W-1:0]    r_req_slot;
    logic                r_req_inrange;
    logic [TIME_W-1:0]   r_req_sub;
    logic [TIME_W-1:0]   r_req_run;

    // Selection scan.
    logic [CNT_W-1:0]    r_idx;
    logic                r_any_arr;
    logic                r_any_pend;
    logic [IDX_W-1:0]    r_best_idx;
    logic [NUM_W-1:0]    r_best_num;
    logic [TIME_W-1:0]   r_best_sub;
    logic [TIME_W-1:0]   r_best_run;
    logic [IDX_W-1:0]    r_early_idx;
    logic [TIME_W-1:0]   r_early_sub;
    logic [TIME_W-1:0]   r_early_run;
    logic [PROD_W-1:0]   r_prod;
    logic                r_mul_sel;

    // Response register.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [TIME_W-1:0]   r_out_start;
    logic [TIME_W-1:0]   r_out_end;
    logic [TIME_W-1:0]   r_out_turn;
    logic [TIME_W-1:0]   r_out_now;

    logic [EXT_W-1:0]    w_slot_ext;
    logic [EXT_W-1:0]    w_act_ext;
    logic                w_wr_en;
    logic [ENT_W-1:0]    w_rd_data;
    logic [IDX_W-1:0]    w_idx_slot;
    logic [TIME_W-1:0]   w_cand_sub;
    logic [TIME_W-1:0]   w_cand_run;
    logic                w_cand_arr;
    logic [NUM_W-1:0]    w_cand_num;
    logic [NUM_W-1:0]    w_mul_a;
    logic [TIME_W-1:0]   w_mul_b;
    logic [PROD_W-1:0]   w_mul;
    logic                w_out_free;
    logic                w_act_arr;
    logic                w_finish;
    logic [TIME_W-1:0]   n_now;
    logic [TIME_W-1:0]   n_remaining;
    logic [TIME_W-1:0]   n_job_start;

    assign w_slot_ext = EXT_W'(i_slot);
    assign w_act_ext  = EXT_W'(r_active);
    assign w_idx_slot = r_idx[IDX_W-1:0];

    // Job table: submit time in the upper half, run time in the lower half.
    assign w_wr_en = i_cmd.do_load && !r_busy && r_req_inrange;

    hjs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_JOBS)
    ) u_job_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_req_slot),
        .i_wr_data ({r_req_sub, r_req_run}),
        .i_rd_addr (w_idx_slot),
        .o_rd_data (w_rd_data)
    );

    // Candidate under the scan index and its ratio numerator.
    assign w_cand_sub = w_rd_data[ENT_W-1:TIME_W];
    assign w_cand_run = w_rd_data[TIME_W-1:0];
    assign w_cand_arr = (w_cand_sub <= r_now);
    assign w_cand_num = NUM_W'(r_now - w_cand_sub) + NUM_W'(w_cand_run);

    // One shared multiplier for both sides of the cross-multiplied compare.
    // The second side is used in the cycle after the first product was loaded.
    assign w_mul_a = r_mul_sel ? r_best_num : w_cand_num;
    assign w_mul_b = r_mul_sel ? w_cand_run : r_best_run;
    assign w_mul   = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // Tick step for the committed job.
    assign w_out_free  = !r_out_valid || i_rsp_ready;
    assign w_act_arr   = (r_act_sub <= r_now);
    assign n_now       = (r_now != TIME_MAX) ? (r_now + TIME_W'(1)) : r_now;
    assign n_job_start = (r_remaining == r_act_run) ? r_now : r_job_start;
    assign n_remaining = (r_remaining != '0) ? (r_remaining - TIME_W'(1)) : r_remaining;
    assign w_finish    = w_act_arr && (n_remaining == '0);

    // Status toward the controller.
    always_comb begin
        o_sts.busy          = r_busy;
        o_sts.out_free      = w_out_free;
        o_sts.idx_end       = (r_idx == CNT_W'(MAX_JOBS));
        o_sts.idx_pending   = r_slot_valid[w_idx_slot] && !r_slot_done[w_idx_slot];
        o_sts.cand_arrived  = w_cand_arr;
        o_sts.any_arr       = r_any_arr;
        o_sts.any_pend      = r_any_pend;
        o_sts.ratio_greater = (r_prod > w_mul);
        o_sts.early_better  = !r_any_pend || (w_cand_sub < r_early_sub);
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_slot_done  <= '0;
            r_now        <= '0;
            r_remaining  <= '0;
            r_job_start  <= '0;
            r_active     <= '0;
            r_busy       <= 1'b0;
            r_idx        <= '0;
            r_any_arr    <= 1'b0;
            r_any_pend   <= 1'b0;
            r_mul_sel    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mul_sel <= i_cmd.prod_load;
            if (w_wr_en) begin
                r_slot_valid[r_req_slot] <= 1'b1;
                r_slot_done[r_req_slot]  <= 1'b0;
            end
            if (i_cmd.scan_start) begin
                r_idx      <= '0;
                r_any_arr  <= 1'b0;
                r_any_pend <= 1'b0;
            end else if (i_cmd.scan_next) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.best_take) begin
                r_any_arr <= 1'b1;
            end
            if (i_cmd.early_take) begin
                r_any_pend <= 1'b1;
            end
            if (i_cmd.commit_best) begin
                r_active    <= r_best_idx;
                r_remaining <= r_best_run;
                r_busy      <= 1'b1;
            end else if (i_cmd.commit_early) begin
                r_active    <= r_early_idx;
                r_remaining <= r_early_run;
                r_busy      <= 1'b1;
            end
            if (i_cmd.do_exec) begin
                r_now <= n_now;
                if (w_act_arr) begin
                    r_job_start <= n_job_start;
                    r_remaining <= n_remaining;
                end
                if (w_finish) begin
                    r_slot_done[r_active] <= 1'b1;
                    r_busy                <= 1'b0;
                end
            end
            if (i_cmd.do_load || i_cmd.do_exec || i_cmd.do_empty) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: captured request, scan candidates, active job and response.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_slot    <= w_slot_ext[IDX_W-1:0];
            r_req_inrange <= (int'(i_slot) < MAX_JOBS);
            r_req_sub     <= i_submit_time;
            r_req_run     <= (i_run_time == '0) ? TIME_W'(1) : i_run_time;
        end
        if (i_cmd.prod_load) begin
            r_prod <= w_mul;
        end
        if (i_cmd.best_take) begin
            r_best_idx <= w_idx_slot;
            r_best_num <= w_cand_num;
            r_best_sub <= w_cand_sub;
            r_best_run <= w_cand_run;
        end
        if (i_cmd.early_take) begin
            r_early_idx <= w_idx_slot;
            r_early_sub <= w_cand_sub;
            r_early_run <= w_cand_run;
        end
        if (i_cmd.commit_best) begin
            r_act_sub <= r_best_sub;
            r_act_run <= r_best_run;
        end else if (i_cmd.commit_early) begin
            r_act_sub <= r_early_sub;
            r_act_run <= r_early_run;
        end
        if (i_cmd.do_load) begin
            r_out_status <= ST_IDLE;
            r_out_slot   <= '0;
            r_out_start  <= '0;
            r_out_end    <= '0;
            r_out_turn   <= '0;
            r_out_now    <= r_now;
        end else if (i_cmd.do_empty) begin
            r_out_status <= ST_ALL_DONE;
            r_out_slot   <= '0;
            r_out_start  <= '0;
            r_out_end    <= '0;
            r_out_turn   <= '0;
            r_out_now    <= r_now;
        end else if (i_cmd.do_exec) begin
            r_out_now <= n_now;
            if (w_finish) begin
                r_out_status <= ST_FINISHED;
                r_out_slot   <= w_act_ext[SLOT_W-1:0];
                r_out_start  <= n_job_start;
                r_out_end    <= n_now;
                r_out_turn   <= n_now - r_act_sub;
            end else begin
                r_out_status <= w_act_arr ? ST_RUNNING : ST_IDLE;
                r_out_slot   <= '0;
                r_out_start  <= '0;
                r_out_end    <= '0;
                r_out_turn   <= '0;
            end
        end
    end

    assign o_rsp_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_finished_slot = r_out_slot;
    assign o_start_time    = r_out_start;
    assign o_end_time      = r_out_end;
    assign o_turnaround    = r_out_turn;
    assign o_current_time  = r_out_now;

`ifndef SYNTHESIS
    // A committed job is always a loaded slot that has not finished.
    a_busy_slot_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_slot_valid[r_active] && !r_slot_done[r_active]))
        else $error("committed job slot is not live");

    // A committed job always has run time left.
    a_busy_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_remaining != '0))
        else $error("committed job has no remaining time");

    // The scheduler clock never runs backward.
    a_time_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_now >= $past(r_now)))
        else $error("scheduler time decreased");
`endif
endmodule

[hdl/hjs_ctrl.sv]
// Controller state machine of the job scheduler: request handling and selection scan sequencing.
`timescale 1ns / 1ps

module hjs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_action,
    output logic             o_req_ready,
    input  hjs_pkg::t_dp_sts i_sts,
    output hjs_pkg::t_dp_cmd o_cmd
);
    import hjs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_CHK   = 8'b0000_0100,
        S_CMP1  = 8'b0000_1000,
        S_CMP2  = 8'b0001_0000,
        S_PICK  = 8'b0010_0000,
        S_EXEC  = 8'b0100_0000,
        S_EMPTY = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_req_ready = (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_req_action == ACT_TICK) begin
                        if (i_sts.busy) begin
                            n_state = S_EXEC;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_CHK;
                        end
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.do_load = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_CHK: begin
                // Skip slots that are empty or done; read the table for the rest.
                if (i_sts.idx_end) begin
                    n_state = S_PICK;
                end else if (i_sts.idx_pending) begin
                    n_state = S_CMP1;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_CMP1: begin
                if (i_sts.cand_arrived) begin
                    if (!i_sts.any_arr) begin
                        o_cmd.best_take = 1'b1;
                        o_cmd.scan_next = 1'b1;
                        n_state         = S_CHK;
                    end else begin
                        o_cmd.prod_load = 1'b1;
                        n_state         = S_CMP2;
                    end
                end else begin
                    o_cmd.early_take = i_sts.early_better;
                    o_cmd.scan_next  = 1'b1;
                    n_state          = S_CHK;
                end
            end
            S_CMP2: begin
                // Second cross product against the one held from the previous cycle.
                o_cmd.best_take = i_sts.ratio_greater;
                o_cmd.scan_next = 1'b1;
                n_state         = S_CHK;
            end
            S_PICK: begin
                if (i_sts.any_arr) begin
                    o_cmd.commit_best = 1'b1;
                    n_state           = S_EXEC;
                end else if (i_sts.any_pend) begin
                    o_cmd.commit_early = 1'b1;
                    n_state            = S_EXEC;
                end else begin
                    n_state = S_EMPTY;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.do_exec = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.do_empty = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // The pick happens only once the scan has passed the last slot.
    a_pick_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) |-> ($past(r_state) == S_CHK))
        else $error("pick entered before the scan finished");
`endif
endmodule

[hdl/hrrn_job_scheduler.sv]
// Top level of the highest-response-ratio-next job scheduler.
// A load, or a tick with a job already committed, is captured in the idle state and answered from the
// response register once it is free. A tick that must pick a job first scans every slot: empty or done
// slots are skipped, others are read from the table and compared (one shared multiplier).
// One request is in work at a time; the next is taken while the response register waits.
// Reset (synchronous, active low) clears slot flags, time and the committed job; tables keep data.
`timescale 1ns / 1ps

module hrrn_job_scheduler #(
    parameter int MAX_JOBS = hjs_pkg::DEF_MAX_JOBS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hjs_req_if.sink    i_req,
    hjs_rsp_if.source  o_rsp
);
    import hjs_pkg::*;

    t_dp_cmd             w_cmd;
    t_dp_sts             w_sts;
    logic                w_req_ready;
    logic                w_rsp_valid;
    logic [STATUS_W-1:0] w_status;
    logic [SLOT_W-1:0]   w_finished_slot;
    logic [TIME_W-1:0]   w_start_time;
    logic [TIME_W-1:0]   w_end_time;
    logic [TIME_W-1:0]   w_turnaround;
    logic [TIME_W-1:0]   w_current_time;

    // Controller.
    hjs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_action (i_req.action),
        .o_req_ready  (w_req_ready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    // Datapath.
    hjs_datapath #(
        .MAX_JOBS (MAX_JOBS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_slot          (i_req.slot),
        .i_submit_time   (i_req.submit_time),
        .i_run_time      (i_req.run_time),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_rsp_ready     (o_rsp.ready),
        .o_rsp_valid     (w_rsp_valid),
        .o_status        (w_status),
        .o_finished_slot (w_finished_slot),
        .o_start_time    (w_start_time),
        .o_end_time      (w_end_time),
        .o_turnaround    (w_turnaround),
        .o_current_time  (w_current_time)
    );

    // Channel hookup.
    assign i_req.ready         = w_req_ready;
    assign o_rsp.valid         = w_rsp_valid;
    assign o_rsp.status        = w_status;
    assign o_rsp.finished_slot = w_finished_slot;
    assign o_rsp.start_time    = w_start_time;
    assign o_rsp.end_time      = w_end_time;
    assign o_rsp.turnaround    = w_turnaround;
    assign o_rsp.current_time  = w_current_time;
endmodule
